/* src/swa_pkg.sv */
// ----------------------------------------------------------------------------
// swa_pkg: shared definitions of the sliding window aggregator
// Widths, mode and register codes, and operation codes of the shared unit.
// ----------------------------------------------------------------------------
package swa_pkg;

	// default parameter values
	localparam int WINDOW_DEPTH_DEF = 64;
	localparam int NUM_CHANNELS_DEF = 4;
	localparam int SAMPLE_BITS_DEF  = 32;

	// fixed field widths
	localparam int SAMPLE_PORT_BITS = 32;
	localparam int CHANNEL_BITS     = 2;
	localparam int AGG_BITS         = 38;
	localparam int COUNT_BITS       = 7;
	localparam int MODE_BITS        = 3;
	localparam int CFG_INDEX_BITS   = 3;
	localparam int CFG_DATA_BITS    = 7;
	localparam int MODE_REGS        = 4;

	// window sum of up to 127 samples of 32 bits
	localparam int ACC_BITS  = 39;
	// shared adder width, one guard bit for compares
	localparam int ALU_BITS  = ACC_BITS + 1;
	// Q16.16 fraction bits
	localparam int FRAC_BITS = 16;

	// aggregate function codes
	localparam logic [MODE_BITS-1:0] MODE_SUM    = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_AVG    = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_MIN    = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_MAX    = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_COUNT  = 3'd4;
	localparam logic [MODE_BITS-1:0] MODE_OLDEST = 3'd5;
	localparam logic [MODE_BITS-1:0] MODE_NEWEST = 3'd6;

	// input commands
	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// register index codes
	localparam logic [CFG_INDEX_BITS-1:0] REG_MODE_CH0   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_CH0 = 3'd4;

	// shared unit operations
	typedef logic [1:0] alu_op_t;
	localparam alu_op_t ALU_ADD = 2'd0;
	localparam alu_op_t ALU_SUB = 2'd1;
	localparam alu_op_t ALU_MIN = 2'd2;
	localparam alu_op_t ALU_MAX = 2'd3;

endpackage

/* src/swa_if.sv */
// ----------------------------------------------------------------------------
// swa_in_if / swa_out_if: sample and result channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface swa_in_if;
	logic                                       valid;
	logic                                       ready;
	logic                                       command;
	logic [swa_pkg::CHANNEL_BITS-1:0]           channel;
	logic signed [swa_pkg::SAMPLE_PORT_BITS-1:0] sample;

	modport source (output valid, command, channel, sample, input ready);
	modport sink   (input valid, command, channel, sample, output ready);
endinterface

interface swa_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [swa_pkg::CHANNEL_BITS-1:0]     channel_out;
	logic signed [swa_pkg::AGG_BITS-1:0]  aggregate;
	logic [swa_pkg::COUNT_BITS-1:0]       window_count;

	modport source (output valid, channel_out, aggregate, window_count, input ready);
	modport sink   (input valid, channel_out, aggregate, window_count, output ready);
endinterface

/* src/sliding_window_aggregator_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_aggregator_top: per-channel sliding window aggregate
// Sequencer around a sample memory and a shared add/compare unit.
// ----------------------------------------------------------------------------
// Items arrive on samples (command, channel, sample). A push stores the sample
// in its channel's ring and returns one result on results: channel_out, the
// aggregate over the newest n = min(fill, window) samples and n. A clear
// empties the channel and returns a zero aggregate with n = 0. Items for a
// channel number at or above NUM_CHANNELS are taken and dropped.
// The block handles one item at a time; samples.ready is high only when idle.
// Each item passes the write state. Count mode, mode seven and a clear then
// go straight to the done state; sum, min, max, oldest and average scan all
// n stored samples, and newest reads only the newest one. The average
// follows its scan with an abs, a division and a negate state. The scan
// reads one stored sample a cycle through the single memory read port; the
// average adds a 39-step restoring division on the shared adder.
// The finished result sits in an output register; the next item is taken
// while it waits. If results stalls, the following item holds at its end
// until the register frees. Reset empties all channels, sets every mode to
// sum and every window to 16; memory contents need no clearing.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
module sliding_window_aggregator_top #(
	parameter int WINDOW_DEPTH = swa_pkg::WINDOW_DEPTH_DEF,
	parameter int NUM_CHANNELS = swa_pkg::NUM_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = swa_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	swa_in_if.sink                              samples,
	swa_out_if.source                           results,
	input  logic                                cfg_write,
	input  logic [swa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [swa_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int CW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int PW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FW  = $clog2(WINDOW_DEPTH + 1);
	localparam int NW  = (FW > swa_pkg::COUNT_BITS) ? FW : swa_pkg::COUNT_BITS;
	localparam int SW  = (SAMPLE_BITS < swa_pkg::SAMPLE_PORT_BITS) ?
		SAMPLE_BITS : swa_pkg::SAMPLE_PORT_BITS;
	localparam int AB  = swa_pkg::ACC_BITS;
	localparam int LB  = swa_pkg::ALU_BITS;
	localparam int GB  = swa_pkg::AGG_BITS;
	localparam int CB  = swa_pkg::COUNT_BITS;
	localparam int DCW = $clog2(AB);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WRITE = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_ABS   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_NEG   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]                     state_q;
	logic [swa_pkg::MODE_BITS-1:0]  mode_q   [swa_pkg::MODE_REGS];
	logic [CB-1:0]                  window_q [swa_pkg::MODE_REGS];
	logic [PW-1:0]                  wp_q     [NUM_CHANNELS];
	logic [FW-1:0]                  fill_q   [NUM_CHANNELS];

	logic [CW-1:0]                  ch_q;
	logic                           cmd_q;
	logic [SW-1:0]                  sample_q;
	logic [swa_pkg::MODE_BITS-1:0]  fn_q;
	logic [CB-1:0]                  n_q;
	logic [CB-1:0]                  lim_q;
	logic [CB-1:0]                  iss_q;
	logic [CB-1:0]                  pc_q;
	logic [PW-1:0]                  ptr_q;
	logic                           rdv_q;
	logic signed [AB-1:0]           acc_q;
	logic [CB-1:0]                  rem_q;
	logic                           neg_q;
	logic [DCW-1:0]                 dcnt_q;

	logic                           out_valid_q;
	logic [swa_pkg::CHANNEL_BITS-1:0] out_ch_q;
	logic signed [GB-1:0]           out_agg_q;
	logic [CB-1:0]                  out_n_q;

	logic                           in_xfer;
	logic                           out_xfer;
	logic                           ch_ok;
	logic [swa_pkg::MODE_BITS-1:0]  mode_cur;
	logic [FW-1:0]                  fill_new;
	logic [NW-1:0]                  win_c;
	logic [NW-1:0]                  fill_w;
	logic [CB-1:0]                  n_new;
	logic                           issue;
	logic [SW-1:0]                  rd_data;
	logic signed [LB-1:0]           rd_ext;
	logic [CB:0]                    div_num;
	logic                           load_out;
	logic signed [GB-1:0]           agg_sat;

	swa_pkg::alu_op_t               alu_op;
	logic signed [LB-1:0]           alu_a;
	logic signed [LB-1:0]           alu_b;
	logic signed [LB-1:0]           alu_y;
	logic                           alu_neg;

	// handshakes
	assign samples.ready = (state_q == ST_IDLE);
	assign in_xfer       = samples.valid && samples.ready;
	assign out_xfer      = results.valid && results.ready;
	assign ch_ok         = ({{(32-swa_pkg::CHANNEL_BITS){1'b0}}, samples.channel}
		< 32'(NUM_CHANNELS));
	assign load_out      = (state_q == ST_DONE) && (!out_valid_q || results.ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < swa_pkg::MODE_REGS; i++) begin
				mode_q[i]   <= swa_pkg::MODE_SUM;
				window_q[i] <= CB'(16);
			end
		end else if (cfg_write) begin
			if (cfg_index < swa_pkg::REG_WINDOW_CH0) begin
				mode_q[cfg_index[1:0]] <= cfg_data[swa_pkg::MODE_BITS-1:0];
			end else begin
				window_q[cfg_index[1:0]] <= cfg_data[CB-1:0];
			end
		end
	end

	// window length and sample count after this push
	assign mode_cur = mode_q[2'(ch_q)];
	assign fill_new = (fill_q[ch_q] < FW'(WINDOW_DEPTH)) ? FW'(fill_q[ch_q] + 1'b1)
		: fill_q[ch_q];
	assign fill_w   = NW'(fill_new);
	always_comb begin
		win_c = NW'(window_q[2'(ch_q)]);
		if (win_c == '0) begin
			win_c = NW'(1);
		end
		if (win_c > NW'(WINDOW_DEPTH)) begin
			win_c = NW'(WINDOW_DEPTH);
		end
	end
	assign n_new = (fill_w < win_c) ? fill_w[CB-1:0] : win_c[CB-1:0];

	// sample memory
	assign issue  = (state_q == ST_SCAN) && (iss_q < lim_q);
	assign rd_ext = LB'(signed'(rd_data));

	swa_store #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.STORE_BITS   (SW)
	) u_store (
		.clk     (clk),
		.wr_en   ((state_q == ST_WRITE) && (cmd_q == swa_pkg::CMD_PUSH)),
		.wr_ch   (ch_q),
		.wr_pos  (wp_q[ch_q]),
		.wr_data (sample_q),
		.rd_en   (issue),
		.rd_ch   (ch_q),
		.rd_pos  (ptr_q),
		.rd_data (rd_data)
	);

	// division step operand: shifted remainder with next dividend bit
	assign div_num = {rem_q, acc_q[AB-1]};

	// shared unit operand select
	always_comb begin
		alu_op = swa_pkg::ALU_ADD;
		alu_a  = LB'(acc_q);
		alu_b  = rd_ext;
		case (state_q)
			ST_SCAN: begin
				case (fn_q)
					swa_pkg::MODE_MIN: begin
						alu_op = swa_pkg::ALU_MIN;
						alu_a  = rd_ext;
						alu_b  = LB'(acc_q);
					end
					swa_pkg::MODE_MAX: alu_op = swa_pkg::ALU_MAX;
					default:           alu_op = swa_pkg::ALU_ADD;
				endcase
			end
			ST_ABS, ST_NEG: begin
				alu_op = swa_pkg::ALU_SUB;
				alu_a  = '0;
				alu_b  = LB'(acc_q);
			end
			ST_DIV: begin
				alu_op = swa_pkg::ALU_SUB;
				alu_a  = LB'(div_num);
				alu_b  = LB'(n_q);
			end
			default: alu_op = swa_pkg::ALU_ADD;
		endcase
	end

	swa_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.y   (alu_y),
		.neg (alu_neg)
	);

	// sequencer and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdv_q   <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				wp_q[i]   <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			rdv_q <= issue;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && ch_ok) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (cmd_q == swa_pkg::CMD_CLEAR) begin
						wp_q[ch_q]   <= '0;
						fill_q[ch_q] <= '0;
						state_q      <= ST_DONE;
					end else begin
						wp_q[ch_q]   <= (wp_q[ch_q] == PW'(WINDOW_DEPTH - 1)) ? '0
							: PW'(wp_q[ch_q] + 1'b1);
						fill_q[ch_q] <= fill_new;
						if (mode_cur == swa_pkg::MODE_COUNT ||
							mode_cur > swa_pkg::MODE_NEWEST) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rdv_q && (CB'(pc_q + 1'b1) == lim_q)) begin
						state_q <= (fn_q == swa_pkg::MODE_AVG) ? ST_ABS : ST_DONE;
					end
				end
				ST_ABS: state_q <= ST_DIV;
				ST_DIV: begin
					if (dcnt_q == DCW'(AB - 1)) begin
						state_q <= ST_NEG;
					end
				end
				ST_NEG: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ch_q     <= samples.channel[CW-1:0];
				cmd_q    <= samples.command;
				sample_q <= samples.sample[SW-1:0];
			end
			ST_WRITE: begin
				fn_q  <= mode_cur;
				ptr_q <= wp_q[ch_q];
				iss_q <= '0;
				pc_q  <= '0;
				if (cmd_q == swa_pkg::CMD_CLEAR) begin
					n_q   <= '0;
					acc_q <= '0;
				end else begin
					n_q   <= n_new;
					lim_q <= (mode_cur == swa_pkg::MODE_NEWEST) ? CB'(1) : n_new;
					if (mode_cur == swa_pkg::MODE_COUNT) begin
						acc_q <= AB'({n_new, {swa_pkg::FRAC_BITS{1'b0}}});
					end else begin
						acc_q <= '0;
					end
				end
			end
			ST_SCAN: begin
				// walk from the newest sample back toward the oldest
				if (issue) begin
					ptr_q <= (ptr_q == '0) ? PW'(WINDOW_DEPTH - 1) : PW'(ptr_q - 1'b1);
					iss_q <= CB'(iss_q + 1'b1);
				end
				if (rdv_q) begin
					pc_q <= CB'(pc_q + 1'b1);
					if (pc_q == '0 || fn_q == swa_pkg::MODE_OLDEST) begin
						acc_q <= rd_ext[AB-1:0];
					end else begin
						acc_q <= alu_y[AB-1:0];
					end
				end
			end
			ST_ABS: begin
				neg_q  <= acc_q[AB-1];
				rem_q  <= '0;
				dcnt_q <= '0;
				if (acc_q[AB-1]) begin
					acc_q <= alu_y[AB-1:0];
				end
			end
			ST_DIV: begin
				// restoring division of the magnitude by n, one bit a cycle
				dcnt_q <= DCW'(dcnt_q + 1'b1);
				acc_q  <= {acc_q[AB-2:0], !alu_neg};
				rem_q  <= alu_neg ? div_num[CB-1:0] : alu_y[CB-1:0];
			end
			ST_NEG: begin
				if (neg_q) begin
					acc_q <= alu_y[AB-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// saturate to the aggregate range
	always_comb begin
		if (acc_q[AB-1] != acc_q[GB-1]) begin
			agg_sat = acc_q[AB-1] ? {1'b1, {(GB-1){1'b0}}} : {1'b0, {(GB-1){1'b1}}};
		end else begin
			agg_sat = acc_q[GB-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ch_q  <= swa_pkg::CHANNEL_BITS'(ch_q);
			out_agg_q <= agg_sat;
			out_n_q   <= n_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.channel_out  = out_ch_q;
	assign results.aggregate    = out_agg_q;
	assign results.window_count = out_n_q;

endmodule

/* src/swa_store.sv */
// ----------------------------------------------------------------------------
// swa_store: per-channel sample rings
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swa_store #(
	parameter int NUM_CHANNELS = swa_pkg::NUM_CHANNELS_DEF,
	parameter int WINDOW_DEPTH = swa_pkg::WINDOW_DEPTH_DEF,
	parameter int STORE_BITS   = swa_pkg::SAMPLE_PORT_BITS,
	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
	localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [CW-1:0]         wr_ch,
	input  logic [PW-1:0]         wr_pos,
	input  logic [STORE_BITS-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [CW-1:0]         rd_ch,
	input  logic [PW-1:0]         rd_pos,
	output logic [STORE_BITS-1:0] rd_data
);

	logic [STORE_BITS-1:0] mem [NUM_CHANNELS][WINDOW_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ch][wr_pos] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_ch][rd_pos];
		end
	end

endmodule

/* src/swa_alu.sv */
// ----------------------------------------------------------------------------
// swa_alu: shared add, subtract and compare unit
// One adder serves window sums, min/max compares, negation and division steps.
// ----------------------------------------------------------------------------
module swa_alu (
	input  swa_pkg::alu_op_t                    op,
	input  logic signed [swa_pkg::ALU_BITS-1:0] a,
	input  logic signed [swa_pkg::ALU_BITS-1:0] b,
	output logic signed [swa_pkg::ALU_BITS-1:0] y,
	output logic                                neg
);

	logic                                sub;
	logic signed [swa_pkg::ALU_BITS-1:0] sum;

	// single adder, b inverted for subtract and compare
	assign sub = (op != swa_pkg::ALU_ADD);
	assign sum = a + (sub ? ~b : b) + {{(swa_pkg::ALU_BITS-1){1'b0}}, sub};
	assign neg = sum[swa_pkg::ALU_BITS-1];

	// result select
	always_comb begin
		case (op)
			swa_pkg::ALU_ADD: y = sum;
			swa_pkg::ALU_SUB: y = sum;
			swa_pkg::ALU_MIN: y = neg ? a : b;
			swa_pkg::ALU_MAX: y = neg ? b : a;
			default:          y = sum;
		endcase
	end

endmodule
